### hdl/sorted_priority_queue_macros.svh
// Assertion helpers shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

### hdl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 16;
  localparam int PRI_W  = 16;
  localparam int OCC_W  = 5;
  localparam int KIND_W = 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cmd_t;

endpackage

### hdl/spq_front.sv
`include "sorted_priority_queue_macros.svh"

module spq_front
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [PRI_W-1:0]  in_priority_req,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  cmd_t               fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               push;
  cmd_t               in_cmd;

  // classify the incoming transfer
  always_comb begin
    in_cmd.id  = in_entry_id;
    in_cmd.pri = in_priority_req;
    unique case (in_kind)
      KIND_INSERT: in_cmd.op = OP_INSERT;
      KIND_REMOVE: in_cmd.op = OP_REMOVE;
      KIND_LOOKUP: in_cmd.op = OP_LOOKUP;
      default:     in_cmd.op = OP_NOP;
    endcase
  end

  assign busy        = (level_r == LVL_W'(FIFO_DEPTH));
  assign push        = start && !busy;
  assign cmd_valid_o = (level_r != '0);
  assign cmd_o       = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && cmd_pop_i) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_cmd;
    end
  end

  `SPQ_ASSERT_NOW(a_lvl_max, clk, rst_n, 1'b1, level_r <= LVL_W'(FIFO_DEPTH))
  `SPQ_ASSERT_NOW(a_pop_nonempty, clk, rst_n, cmd_pop_i, level_r != '0)
  `SPQ_ASSERT_NEXT(a_lvl_up, clk, rst_n, push && !cmd_pop_i, level_r == $past(level_r) + 1'b1)

endmodule

### hdl/spq_back.sv
`include "sorted_priority_queue_macros.svh"

module spq_back
  import spq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_id,
  output logic [PRI_W-1:0] out_priority,
  output logic [OCC_W-1:0] out_occupancy
);

  logic [ID_W-1:0]  ids_r  [DEPTH];
  logic [ID_W-1:0]  ids_nxt [DEPTH];
  logic [PRI_W-1:0] pris_r [DEPTH];
  logic [PRI_W-1:0] pris_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] valid, gt, hit;
  logic             full, empty, sorted_ok;
  status_t          status_nxt;
  logic [ID_W-1:0]  rid_nxt;
  logic [PRI_W-1:0] rpri_nxt;
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [ID_W-1:0]  rid_r;
  logic [PRI_W-1:0] rpri_r;
  logic [OCC_W-1:0] occ_r;

  assign cmd_pop_o = cmd_valid_i;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  // per-cell compares, all cells in parallel
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = (CNT_W'(i) < count_r);
      gt[i]    = valid[i] && (pris_r[i] > cmd_i.pri);
      hit[i]   = valid[i] && (ids_r[i] == cmd_i.id);
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      if (valid[i] && (pris_r[i-1] < pris_r[i])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  always_comb begin
    ids_nxt    = ids_r;
    pris_nxt   = pris_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rid_nxt    = '0;
    rpri_nxt   = '0;
    if (cmd_valid_i) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            // cells holding a strictly higher priority stay, the first other
            // cell takes the new entry, the rest shift down by one
            if (!gt[0]) begin
              ids_nxt[0]  = cmd_i.id;
              pris_nxt[0] = cmd_i.pri;
            end
            for (int i = 1; i < DEPTH; i++) begin
              if (!gt[i]) begin
                if (gt[i-1]) begin
                  ids_nxt[i]  = cmd_i.id;
                  pris_nxt[i] = cmd_i.pri;
                end else begin
                  ids_nxt[i]  = ids_r[i-1];
                  pris_nxt[i] = pris_r[i-1];
                end
              end
            end
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rid_nxt  = ids_r[0];
            rpri_nxt = pris_r[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
              ids_nxt[i]  = ids_r[i+1];
              pris_nxt[i] = pris_r[i+1];
            end
            count_nxt = count_r - 1'b1;
          end
        end
        OP_LOOKUP: begin
          status_nxt = (|hit) ? ST_OK : ST_NOTFOUND;
        end
        OP_NOP: begin
          status_nxt = ST_OK;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    ids_r    <= ids_nxt;
    pris_r   <= pris_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    rpri_r   <= rpri_nxt;
    occ_r    <= OCC_W'(count_nxt);
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_id        = rid_r;
  assign out_priority  = rpri_r;
  assign out_occupancy = occ_r;

  `SPQ_ASSERT_NOW(a_cnt_max, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NOW(a_sorted, clk, rst_n, 1'b1, sorted_ok)
  `SPQ_ASSERT_NEXT(a_pop_result, clk, rst_n, cmd_pop_o, out_valid_r)
  `SPQ_ASSERT_NEXT(a_rem_dec, clk, rst_n, cmd_valid_i && cmd_i.op == OP_REMOVE && !empty, count_r == $past(count_r) - 1'b1)

endmodule

### hdl/sorted_priority_queue.sv
// A command taken at a clock edge is first written into the command queue;
// the back end then applies it and registers the result strobe. One command
// per cycle is sustained, as the parallel cell array updates all cells at once.
// busy rises only if the two-entry command queue fills, which the back end
// never lets happen since it drains one command every cycle.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [PRI_W-1:0]  in_priority_req,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [ID_W-1:0]   out_id,
  output logic [PRI_W-1:0]  out_priority,
  output logic [OCC_W-1:0]  out_occupancy
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  spq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_entry_id     (in_entry_id),
    .in_priority_req (in_priority_req),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  spq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .out_occupancy (out_occupancy)
  );

endmodule
